FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int MAG_W = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_out_word;

    // GCD engine control
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] x;
        logic [MAG_W-1:0] y;
    } t_gcd_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] g;
    } t_gcd_rsp;

endpackage

FILE: rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Binary GCD of two 64-bit magnitudes, one subtract/shift step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd
    import rau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_gcd_req i_req,
    output t_gcd_rsp o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [MAG_W-1:0] r_x, n_x, r_y, n_y;
    logic [6:0]       r_k, n_k;
    logic             r_done, n_done;
    logic [MAG_W-1:0] w_diff;

    assign w_diff = (r_x > r_y) ? r_x - r_y : r_y - r_x;

    // step: strip common twos, then odd-only subtract and shift
    always_comb begin
        n_state = r_state;
        n_x = r_x;
        n_y = r_y;
        n_k = r_k;
        n_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_x = i_req.x;
                    n_y = i_req.y;
                    n_k = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_y == '0) begin
                    n_state = S_FIX;
                end else if (r_x == '0) begin
                    n_x = r_y;
                    n_y = '0;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 7'd1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else begin
                    n_x = (r_x < r_y) ? r_x : r_y;
                    n_y = w_diff >> 1;
                end
            end
            S_FIX: begin
                n_x = r_x << r_k[5:0];
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_k <= n_k;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.g    = r_x;

endmodule

FILE: rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider of a 64-bit magnitude by a 64-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module rau_div
    import rau_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [MAG_W-1:0] i_divisor,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [6:0]       r_cnt;
    logic [MAG_W-1:0] r_q, r_d;
    logic [MAG_W:0]   r_rem;
    logic [MAG_W:0]   w_sh;

    assign w_sh = {r_rem[MAG_W-1:0], r_q[MAG_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'(MAG_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        // shift-subtract step
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (w_sh >= {1'b0, r_d}) begin
                r_rem <= w_sh - {1'b0, r_d};
                r_q   <= {r_q[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/rational_arith_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// Rational add/sub/mul/div/compare with GCD reduction.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A zero denominator or a divide by zero
// ends the word early with a status result, a compare skips the reduction,
// and a zero numerator skips the GCD. Other arithmetic runs the binary GCD
// over a 64-bit magnitude and then two bit-serial divisions by the GCD.
// The result waits in an output register until taken. The next word can be
// taken meanwhile; the sequencer holds in its last step while the previous
// result is still waiting.
module rational_arith_unit_core
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_COMB = 4'd3;
    localparam logic [3:0] S_GCD  = 4'd4;
    localparam logic [3:0] S_DIVM = 4'd5;
    localparam logic [3:0] S_DIVD = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_MUL2 = 4'd9;

    localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

    logic [3:0]         r_state;
    t_in_word           r_in;
    logic signed [32:0] r_an, r_ad, r_bn, r_bd;
    logic signed [65:0] r_p, r_q, r_dd;
    logic [MAG_W-1:0]   r_m, r_d;
    logic               r_neg;
    t_out_word          r_res;
    t_out_word          r_out;
    logic               r_valid;
    logic               r_gcd_go, r_div_go;
    logic               n_gcd_go, n_div_go;
    logic [MAG_W-1:0]   r_g;

    // shared multiplier: one 33x33 product per cycle
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    assign w_prod = w_ma * w_mb;

    logic [MAG_W-1:0] w_pm, w_qm;
    logic             w_pn, w_qn;
    assign w_pn = r_p < 0;
    assign w_pm = w_pn ? MAG_W'(-r_p) : MAG_W'(r_p);
    assign w_qm = (r_q < 0) ? MAG_W'(-r_q) : MAG_W'(r_q);

    t_gcd_req w_greq;
    t_gcd_rsp w_grsp;
    logic     w_ddone;
    logic [MAG_W-1:0] w_quot;
    logic [MAG_W-1:0] w_dabs;
    logic             w_gcd_rdy;

    assign w_greq.start = r_gcd_go;
    assign w_greq.x     = r_m;
    assign w_greq.y     = r_d;

    rau_gcd u_gcd (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_greq),
        .o_rsp  (w_grsp)
    );

    rau_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_go),
        .i_dividend((r_state == S_DIVM) ? r_m : r_d),
        .i_divisor (r_g),
        .o_done    (w_ddone),
        .o_quot    (w_quot)
    );

    // multiplier operand select by step
    always_comb begin
        w_ma = r_an;
        w_mb = r_bd;
        case (r_state)
            S_MUL: begin
                if (r_in.opcode == OP_MUL) begin
                    w_ma = r_an;
                    w_mb = r_bn;
                end else begin
                    w_ma = r_an;
                    w_mb = r_bd;
                end
            end
            S_MUL2: begin
                w_ma = r_bn;
                w_mb = r_ad;
            end
            S_COMB: begin
                w_ma = r_ad;
                w_mb = (r_in.opcode == OP_DIV) ? r_bn : r_bd;
            end
            default: ;
        endcase
    end

    // GCD and divider launch pulses
    assign w_dabs    = (r_dd < 0) ? MAG_W'(-r_dd) : MAG_W'(r_dd);
    assign w_gcd_rdy = (r_state == S_GCD) && (r_m != '0) && (r_d == w_dabs)
                       && !r_gcd_go && !r_div_go;
    assign n_gcd_go  = w_gcd_rdy && !w_grsp.done && (r_g != '0);
    assign n_div_go  = (w_gcd_rdy && w_grsp.done) || ((r_state == S_DIVM) && w_ddone);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_gcd_go <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_gcd_go <= n_gcd_go;
            r_div_go <= n_div_go;
            // output word handshake
            if (r_state == S_OUT && (!r_valid || i_ready)) r_valid <= 1'b1;
            else if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in    <= i_data;
                        r_res   <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_in.a_den == 0 || r_in.b_den == 0) begin
                        r_res.status <= ST_ZERO;
                        r_state <= S_OUT;
                    end else begin
                        r_an <= r_in.a_den[31] ? -33'(r_in.a_num) : 33'(r_in.a_num);
                        r_ad <= r_in.a_den[31] ? -33'(r_in.a_den) : 33'(r_in.a_den);
                        r_bn <= r_in.b_den[31] ? -33'(r_in.b_num) : 33'(r_in.b_num);
                        r_bd <= r_in.b_den[31] ? -33'(r_in.b_den) : 33'(r_in.b_den);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p <= w_prod;
                    if (r_in.opcode == OP_DIV && r_bn == 0) begin
                        r_res.status <= ST_ZERO;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_q <= w_prod;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    r_dd <= w_prod;
                    case (r_in.opcode)
                        OP_ADD, OP_SUB: begin
                            logic qn;
                            qn = (r_in.opcode == OP_SUB) ? !(r_q < 0) : (r_q < 0);
                            if (r_q == 0) qn = 1'b0;
                            if (w_pn == qn) begin
                                r_m <= w_pm + w_qm;
                                r_neg <= w_pn;
                            end else if (w_pm >= w_qm) begin
                                r_m <= w_pm - w_qm;
                                r_neg <= w_pn;
                            end else begin
                                r_m <= w_qm - w_pm;
                                r_neg <= qn;
                            end
                            r_state <= S_GCD;
                        end
                        OP_MUL: begin
                            r_m <= w_pm;
                            r_neg <= w_pn;
                            r_state <= S_GCD;
                        end
                        OP_DIV: begin
                            // p = an*bd; sign from an and bn
                            r_m <= w_pm;
                            r_neg <= r_an[32] != r_bn[32];
                            r_state <= S_GCD;
                        end
                        default: begin
                            r_res.order <= (r_p < r_q) ? ORD_LT
                                         : ((r_p == r_q) ? ORD_EQ : ORD_GT);
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_GCD: begin
                    // load the denominator magnitude, then start the GCD once
                    if (!r_gcd_go && r_d != w_dabs && r_m != '0) begin
                        r_d <= w_dabs;
                    end
                    if (r_m == '0) begin
                        r_neg <= 1'b0;
                        r_d <= MAG_W'(1);
                        r_state <= S_CHK;
                    end else if (w_gcd_rdy) begin
                        if (w_grsp.done) begin
                            r_g <= w_grsp.g;
                            r_state <= S_DIVM;
                        end else if (r_g != MAG_W'(0)) begin
                            r_g <= '0;
                        end
                    end
                end
                S_DIVM: begin
                    if (w_ddone) begin
                        r_m <= w_quot;
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (w_ddone) begin
                        r_d <= w_quot;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_d > LIM - 1 || (r_neg ? r_m > LIM : r_m > LIM - 1)) begin
                        r_res.status <= ST_OVF;
                    end else begin
                        r_res.res_num <= r_neg ? 32'(-r_m) : 32'(r_m);
                        r_res.res_den <= 31'(r_d);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait here until the previous result has been taken
                    if (!r_valid || i_ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // arm GCD on entry to its step
            if (r_state == S_COMB) r_g <= MAG_W'(1);
        end
    end

    assign o_data = r_out;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the rational arithmetic unit word by word against an in-bench
// predictor: directed corner cases, then one long output hold-off, then random
// fractions with random stalls on both handshakes.
// ----------------------------------------------------------------------------
module tb;
    import rau_pkg::*;

    localparam int          WIDTH     = 32;
    localparam int          N_RANDOM  = 1900;
    localparam longint      MAX_CYC   = 3000000;
    localparam logic [2:0]  OP_CMP    = 3'd4;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    t_out_word expected_q[$];
    int        n_errors = 0;
    longint    cycle_cnt = 0;
    bit        calm = 1'b0;     // no idling while set
    bit        hold_off = 1'b0; // receiver held off for a long stretch

    rational_arith_unit_core #(.WIDTH(WIDTH)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #2 i_clk = ~i_clk;

    // Timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYC) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Predict the reduced fraction for one word
    function automatic t_out_word reduce_fraction(t_in_word w);
        t_out_word r;
        longint an, ad, bn, bd, p, q;
        longint unsigned m, d, g, pm, qm, lim;
        bit neg, pn, qn;
        r = '0;
        an = w.a_num; ad = w.a_den; bn = w.b_num; bd = w.b_den;
        if (ad == 0 || bd == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        if (ad < 0) begin an = -an; ad = -ad; end
        if (bd < 0) begin bn = -bn; bd = -bd; end
        p = an * bd;
        q = bn * ad;
        if (w.opcode >= OP_CMP) begin
            r.order = (p < q) ? ORD_LT : ((p == q) ? ORD_EQ : ORD_GT);
            return r;
        end
        d = longint'(ad) * longint'(bd);
        case (w.opcode)
            OP_ADD, OP_SUB: begin
                pn = p < 0;
                qn = (w.opcode == OP_SUB) ? !(q < 0) : (q < 0);
                if (q == 0) qn = 1'b0;
                pm = mag(p);
                qm = mag(q);
                if (pn == qn) begin m = pm + qm; neg = pn; end
                else if (pm >= qm) begin m = pm - qm; neg = pn; end
                else begin m = qm - pm; neg = qn; end
            end
            OP_MUL: begin
                m = mag(an) * mag(bn);
                neg = (an < 0) != (bn < 0);
            end
            default: begin
                if (bn == 0) begin
                    r.status = ST_ZERO;
                    return r;
                end
                m = mag(an) * longint'(bd);
                neg = (an < 0) != (bn < 0);
                d = longint'(ad) * mag(bn);
            end
        endcase
        if (m == 0) begin
            neg = 1'b0;
            d = 1;
        end else begin
            g = euclid(m, d);
            m = m / g;
            d = d / g;
        end
        lim = 64'd1 << (WIDTH - 1);
        if (d > lim - 1 || (neg ? m > lim : m > lim - 1)) begin
            r.status = ST_OVF;
            return r;
        end
        r.res_num = neg ? 32'(0 - m) : 32'(m);
        r.res_den = 31'(d);
        return r;
    endfunction

    // Receiver: random stalls, or a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_off) i_ready <= 1'b0;
        else i_ready <= calm || ($urandom_range(99) >= 34);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result word %h", o_data);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_data.res_num !== e.res_num) begin
                    $error("res_num exp %0d got %0d", e.res_num, o_data.res_num);
                    n_errors++;
                end
                if (o_data.res_den !== e.res_den) begin
                    $error("res_den exp %0d got %0d", e.res_den, o_data.res_den);
                    n_errors++;
                end
                if (o_data.order !== e.order) begin
                    $error("order exp %0d got %0d", e.order, o_data.order);
                    n_errors++;
                end
                if (o_data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_data.status);
                    n_errors++;
                end
            end
        end
    end

    // Send one word; valid stays high into the next word when no gap follows
    task automatic send_word(t_in_word w);
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(reduce_fraction(w));
        if (!calm) begin
            while ($urandom_range(99) < 34) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic send_frac(logic [2:0] op, int an, int ad, int bn, int bd);
        t_in_word w;
        w.opcode = op; w.a_num = an; w.a_den = ad; w.b_num = bn; w.b_den = bd;
        send_word(w);
    endtask

    function automatic int rand_field();
        case ($urandom_range(5))
            0: return $urandom;                          // full range
            1: return $signed(32'($urandom_range(20))) - 10;
            2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                        : 32'h80000000 + $urandom_range(3);
            3: return $signed(32'($urandom_range(65535))) - 32768;
            default: return $signed(32'($urandom_range(2000))) - 1000;
        endcase
    endfunction

    task automatic test_directed();
        logic [2:0] op;
        for (int k = 0; k <= 4; k++) begin
            op = 3'(k);
            send_frac(op, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        end
        send_frac(OP_ADD, 1, 0, 1, 2);
        send_frac(OP_MUL, 1, 2, 3, 0);
        send_frac(OP_DIV, 3, 4, 0, 5);
        send_frac(OP_ADD, 0, -7, 0, 9);
        send_frac(OP_SUB, 1, 3, 1, 3);
        send_frac(OP_MUL, 32'h80000000, 1, -1, 1);   // overflow of numerator
        send_frac(OP_MUL, 32'h80000000, 1, 1, 1);
        send_frac(OP_ADD, 1, 32'h7fffffff, 1, 32'h7ffffffe); // denominator overflow
        send_frac(OP_DIV, 6, -4, -9, 2);
        send_frac(OP_CMP, -1, 2, 1, -2);
        send_frac(OP_CMP, 1, 3, 1, 2);
        send_frac(OP_CMP, 1, 2, 1, 3);
        send_frac(3'd5, 2, 4, 1, 2);
        send_frac(3'd6, -1, 1, 1, 1);
        send_frac(3'd7, 32'hffffffff, 32'hffffffff, 32'h80000000, 32'h80000000);
        send_frac(OP_ADD, 32'h80000000, 32'h80000000, 0, 1);
    endtask

    task automatic test_random();
        t_in_word w;
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 600 && n < 800);
            w.opcode = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(4));
            w.a_num = rand_field();
            w.a_den = ($urandom_range(30) == 0) ? 0 : rand_field();
            w.b_num = ($urandom_range(20) == 0) ? 0 : rand_field();
            w.b_den = ($urandom_range(30) == 0) ? 0 : rand_field();
            send_word(w);
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        // Receiver stops while the sender keeps offering words
        hold_off = 1'b1;
        calm = 1'b1;
        fork
            begin
                repeat (2000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 12; n++)
                send_frac(3'($urandom_range(4)), rand_field(), rand_field(),
                          rand_field(), rand_field());
        join
        calm = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
